FILE: hdl/slps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slps_pkg
// Shared types and codes for the status LED pattern sequencer: item and
// result payloads, the register set, command, mode and color codes.
// ----------------------------------------------------------------------------
package slps_pkg;

	// Command codes carried in an input item.
	localparam logic [1:0] CMD_TICK    = 2'd0;
	localparam logic [1:0] CMD_SET     = 2'd1;
	localparam logic [1:0] CMD_STOP    = 2'd2;
	localparam logic [1:0] CMD_RESTART = 2'd3;

	// Mode codes.
	localparam logic [2:0] MODE_NONE       = 3'd0;
	localparam logic [2:0] MODE_BLE        = 3'd1;
	localparam logic [2:0] MODE_PEER       = 3'd2;
	localparam logic [2:0] MODE_CONNECTING = 3'd3;
	localparam logic [2:0] MODE_CLOUD      = 3'd4;
	localparam logic [2:0] MODE_ERROR      = 3'd5;

	// LED color codes.
	localparam logic [1:0] COLOR_GREEN = 2'd0;
	localparam logic [1:0] COLOR_BLUE  = 2'd1;
	localparam logic [1:0] COLOR_RED   = 2'd2;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_HAS_RGB       = 2'd0;
	localparam logic [1:0] REG_FAST_BLINK_MS = 2'd1;
	localparam logic [1:0] REG_HEARTBEAT_MS  = 2'd2;
	localparam logic [1:0] REG_SLOW_BLINK_MS = 2'd3;

	// Register reset values.
	localparam logic        HAS_RGB_RST       = 1'b1;
	localparam logic [15:0] FAST_BLINK_MS_RST = 16'd200;
	localparam logic [15:0] HEARTBEAT_MS_RST  = 16'd250;
	localparam logic [15:0] SLOW_BLINK_MS_RST = 16'd2000;

	// Heartbeat pattern limits and elapsed-time saturation value.
	localparam logic [3:0]  BEAT_ON_FIRST = 4'd5;
	localparam logic [3:0]  BEAT_LAST     = 4'd15;
	localparam logic [15:0] ELAPSED_MAX   = 16'hFFFF;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;

	typedef struct packed {
		logic [1:0] cmd;
		logic [2:0] mode_code;
	} slps_item_t;

	typedef struct packed {
		logic       led_on;
		logic [1:0] led_color;
		logic [2:0] active_mode;
	} slps_result_t;

	typedef struct packed {
		logic        has_rgb;
		logic [15:0] fast_blink_ms;
		logic [15:0] heartbeat_ms;
		logic [15:0] slow_blink_ms;
	} slps_cfg_t;

endpackage
`default_nettype wire

FILE: hdl/slps_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slps_cfg_regs
// Configuration register file: color option and the three pattern periods,
// written through a plain write port.
// ----------------------------------------------------------------------------
module slps_cfg_regs
	import slps_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	output slps_cfg_t                   cfg
);

	slps_cfg_t cfg_q;

	// Each register takes the write data when its index is addressed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.has_rgb       <= HAS_RGB_RST;
			cfg_q.fast_blink_ms <= FAST_BLINK_MS_RST;
			cfg_q.heartbeat_ms  <= HEARTBEAT_MS_RST;
			cfg_q.slow_blink_ms <= SLOW_BLINK_MS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HAS_RGB: begin
					cfg_q.has_rgb <= cfg_data[0];
				end
				REG_FAST_BLINK_MS: begin
					cfg_q.fast_blink_ms <= cfg_data;
				end
				REG_HEARTBEAT_MS: begin
					cfg_q.heartbeat_ms <= cfg_data;
				end
				REG_SLOW_BLINK_MS: begin
					cfg_q.slow_blink_ms <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

FILE: hdl/slps_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slps_engine
// Sequencer state and its single-pass update: mode, halt flag, LED level,
// color, elapsed milliseconds and heartbeat step count.
// ----------------------------------------------------------------------------
module slps_engine
	import slps_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         step,
	input  wire slps_item_t   item,
	input  wire slps_cfg_t    cfg,
	output slps_result_t      result
);

	logic [2:0]  cur_mode_q, cur_mode_d;
	logic        halted_q, halted_d;
	logic        lit_q, lit_d;
	logic [1:0]  color_q, color_d;
	logic [15:0] elapsed_q, elapsed_d;
	logic [3:0]  beat_q, beat_d;

	logic [15:0] elapsed_inc;
	logic [15:0] interval;
	logic        set_taken;

	// Saturating millisecond count and the configured pattern period of the mode.
	assign elapsed_inc = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + 16'd1;

	always_comb begin
		case (cur_mode_q)
			MODE_BLE:   interval = cfg.heartbeat_ms;
			MODE_CLOUD: interval = cfg.slow_blink_ms;
			MODE_ERROR: interval = cfg.fast_blink_ms;
			default:    interval = 16'd0;
		endcase
	end

	assign set_taken = (item.mode_code != cur_mode_q) && (cur_mode_q != MODE_ERROR);

	// Next-state logic for one item.
	always_comb begin
		cur_mode_d = cur_mode_q;
		halted_d   = halted_q;
		lit_d      = lit_q;
		color_d    = color_q;
		elapsed_d  = elapsed_q;
		beat_d     = beat_q;
		case (item.cmd)
			CMD_TICK: begin
				elapsed_d = elapsed_inc;
				if (!halted_q) begin
					if (cur_mode_q == MODE_PEER || cur_mode_q == MODE_CONNECTING) begin
						lit_d = 1'b1;
					end else if (interval == 16'd0) begin
						lit_d = 1'b0;
					end else if (elapsed_inc > {1'b0, interval[15:1]}) begin
						// A pattern step fires.
						elapsed_d = 16'd0;
						if (cur_mode_q == MODE_BLE) begin
							if (beat_q == 4'd0) begin
								lit_d  = 1'b0;
								beat_d = beat_q + 4'd1;
							end else if (beat_q >= BEAT_ON_FIRST && beat_q < BEAT_LAST) begin
								lit_d  = 1'b1;
								beat_d = beat_q + 4'd1;
							end else if (beat_q >= BEAT_LAST) begin
								beat_d = 4'd0;
							end else begin
								lit_d  = !lit_q;
								beat_d = beat_q + 4'd1;
							end
						end else begin
							lit_d = !lit_q;
						end
					end
				end
			end
			CMD_SET: begin
				// A repeated mode, or any request while in error, is ignored.
				if (set_taken) begin
					cur_mode_d = item.mode_code;
					elapsed_d  = ELAPSED_MAX;
					case (item.mode_code)
						MODE_BLE, MODE_PEER, MODE_ERROR: begin
							if (cfg.has_rgb) begin
								lit_d   = 1'b0;
								color_d = (item.mode_code == MODE_ERROR) ? COLOR_RED
									: COLOR_BLUE;
							end else begin
								color_d = COLOR_GREEN;
							end
							if (item.mode_code == MODE_BLE) begin
								beat_d = 4'd0;
							end
						end
						MODE_CONNECTING, MODE_CLOUD: begin
							if (cfg.has_rgb) begin
								lit_d = 1'b0;
							end
							color_d = COLOR_GREEN;
						end
						default: begin
						end
					endcase
				end
			end
			CMD_STOP: begin
				halted_d = 1'b1;
				lit_d    = 1'b0;
			end
			default: begin
				halted_d = 1'b0;
			end
		endcase
	end

	// State registers advance once per item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_mode_q <= MODE_NONE;
			halted_q   <= 1'b0;
			lit_q      <= 1'b0;
			color_q    <= COLOR_GREEN;
			elapsed_q  <= 16'd0;
			beat_q     <= 4'd0;
		end else if (step) begin
			cur_mode_q <= cur_mode_d;
			halted_q   <= halted_d;
			lit_q      <= lit_d;
			color_q    <= color_d;
			elapsed_q  <= elapsed_d;
			beat_q     <= beat_d;
		end
	end

	// The result reports the state after this item.
	assign result.led_on      = lit_d;
	assign result.led_color   = color_d;
	assign result.active_mode = cur_mode_d;

endmodule
`default_nettype wire

FILE: hdl/status_led_pattern_sequencer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// status_led_pattern_sequencer_top
// Status LED pattern sequencer: ticks and mode commands in, LED level,
// color and current mode out, one result per item.
// ----------------------------------------------------------------------------
// Usage:
// Items (cmd, mode_code) arrive on the item channel; a transfer happens on a
// clock edge with item_valid high and item_stall low. Each item yields exactly
// one result on the result channel, transferred when result_valid is high and
// result_stall is low.
// An accepted item sits in the input register while the state update is
// computed, and its result then lands in the output register, where
// result_valid rises. One item per cycle is sustained while the receiver
// does not stall; the mode/LED state feedback through the engine is a
// single pass, so back-to-back items never wait on each other.
// When the receiver stalls, the result holds in the output register and the
// input register keeps one more item; item_stall rises only when both are
// full and the output is stalled.
// Reset clears both registers' valid flags and puts the sequencer in mode
// none, LED dark, green, with the registers at their default periods.
// Configuration writes (cfg_we, cfg_index, cfg_data) apply once registered.
// ----------------------------------------------------------------------------
module status_led_pattern_sequencer_top
	import slps_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   item_valid,
	output logic                        item_stall,
	input  wire slps_item_t             item,
	output logic                        result_valid,
	input  wire logic                   result_stall,
	output slps_result_t                result,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	slps_cfg_t    cfg;
	slps_item_t   item_s1;
	logic         valid_s1;
	slps_result_t next_result;
	slps_result_t result_q;
	logic         result_valid_q;
	logic         advance;
	logic         take_item;

	slps_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Input stage moves on when the output register is free or being emptied.
	assign advance    = !result_valid_q || !result_stall;
	assign item_stall = valid_s1 && !advance;
	assign take_item  = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_item) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_item) begin
			item_s1 <= item;
		end
	end

	slps_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (valid_s1 && advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (next_result)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_q <= next_result;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
`default_nettype wire
